/* sv/assert_macros.svh */
// Assertion macros for the port-level checker of the warp unit.
// Self-contained; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled while reset is high.
`define FGW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fgw checker: property failed");

// Next-cycle implication, disabled while reset is high.
`define FGW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fgw checker: property failed");

// Next-cycle implication that also holds across reset.
`define FGW_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fgw checker: property failed");

`endif

/* sv/fgw_pkg.sv */
// Shared constants, codes and types of the frame geometric warp unit.
// No dependencies; the top level and the divider refer to it by scoped names, the testbench files import it.
package fgw_pkg;

  localparam int MAX_DIM = 256;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int DIM_W = COORD_W + 1;
  localparam int ADDR_W = 2 * COORD_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;

  localparam int CHAN_W = 8;
  localparam int PIX_W = 3 * CHAN_W;
  localparam int OUT_W = PIX_W + 1;
  localparam logic [PIX_W-1:0] WHITE = '1;

  localparam int COEF_W = 16;
  localparam int Q_FRAC = 8;
  localparam int OP_W = 2;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_SCATTER = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROTATE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCALE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIRROR_V = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MIRROR_H = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_WARP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd4;

  localparam int DVD_W = COORD_W + Q_FRAC;
  localparam int DVS_W = COEF_W - 1;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/frame_geometric_warp_unit.sv */
// Top level of the frame geometric warp unit: control sequencer and datapath.
// Depends on fgw_pkg, fgw_ram (source and output stores) and fgw_div.

// After reset the unit clears the output store and its marks, one entry per
// cycle, with busy high; configuration writes are taken at all times. An item
// is taken when start is high and busy is low, and busy then stays high until
// the item is finished. A load, an ignored request, a read outside the frame
// or a read whose backward source lies outside the frame ends in the execute
// state; any other read that needs no fill reads the source or output store.
// A carried-out scatter goes through the multiply, truncate and write states
// (four products through one shared multiplier, then the destination check).
// A scale read with both ratios positive and one above one goes through the
// multiply and fill check states, and two 16-step divisions if it fills a
// hole. Each result is shown for exactly one cycle with done high and cannot
// be held off, so the receiver must take it in that cycle.
module frame_geometric_warp_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [fgw_pkg::OP_W-1:0]       opcode,
  input  logic [fgw_pkg::COORD_W-1:0]    pix_x,
  input  logic [fgw_pkg::COORD_W-1:0]    pix_y,
  input  logic [fgw_pkg::CHAN_W-1:0]     in_red,
  input  logic [fgw_pkg::CHAN_W-1:0]     in_green,
  input  logic [fgw_pkg::CHAN_W-1:0]     in_blue,
  output logic                           done,
  output logic [fgw_pkg::CHAN_W-1:0]     out_red,
  output logic [fgw_pkg::CHAN_W-1:0]     out_green,
  output logic [fgw_pkg::CHAN_W-1:0]     out_blue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fgw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MA_W = fgw_pkg::COEF_W + 1;
  localparam int MB_W = fgw_pkg::DIM_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W = PROD_W + 1;
  localparam int MAG_W = ACC_W - fgw_pkg::Q_FRAC;
  localparam int DX_W = MAG_W + 2;
  localparam int SX_W = fgw_pkg::COEF_W + 2;
  localparam int CW = fgw_pkg::COORD_W;
  localparam int DW = fgw_pkg::DIM_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_MUL = 4'd3;
  localparam logic [3:0] S_TRUNC = 4'd4;
  localparam logic [3:0] S_WRITE = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_DIVX = 4'd7;
  localparam logic [3:0] S_DIVY = 4'd8;
  localparam logic [3:0] S_FSRC = 4'd9;
  localparam logic [3:0] S_RSRC = 4'd10;
  localparam logic [3:0] S_ROUT = 4'd11;

  localparam logic [2:0] STEP_LAST = 3'd4;
  localparam logic signed [fgw_pkg::COEF_W-1:0] COEF_ONE = 16'sd256;
  localparam logic signed [MA_W-1:0] MUL_ONE = 17'sd256;

  function automatic logic in_lim(input logic signed [DX_W-1:0] v,
                                  input logic [DW-1:0] lim);
    logic r;
    r = !v[DX_W-1] && (v < $signed({{(DX_W-DW){1'b0}}, lim}));
    return r;
  endfunction

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] step;
  logic [fgw_pkg::ADDR_W-1:0] clr_addr;

  logic [fgw_pkg::MODE_W-1:0] warp_mode;
  logic [DW-1:0] frame_w;
  logic [DW-1:0] frame_h;
  logic signed [fgw_pkg::COEF_W-1:0] coef_x;
  logic signed [fgw_pkg::COEF_W-1:0] coef_y;

  logic [fgw_pkg::OP_W-1:0] op_q;
  logic [CW-1:0] x_q;
  logic [CW-1:0] y_q;
  logic [fgw_pkg::PIX_W-1:0] rgb_q;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] accx;
  logic signed [ACC_W-1:0] accy;
  logic [MAG_W-1:0] magx;
  logic [MAG_W-1:0] magy;
  logic negx;
  logic negy;
  logic [CW-1:0] sx;
  logic [CW-1:0] sy;
  logic [fgw_pkg::PIX_W-1:0] src_q;
  logic [fgw_pkg::OUT_W-1:0] out_q;
  logic [fgw_pkg::PIX_W-1:0] res_pix;

  logic src_we;
  logic src_re;
  logic [fgw_pkg::ADDR_W-1:0] src_raddr;
  logic [fgw_pkg::PIX_W-1:0] src_rdata;
  logic out_we;
  logic out_re;
  logic [fgw_pkg::ADDR_W-1:0] out_waddr;
  logic [fgw_pkg::OUT_W-1:0] out_wdata;
  logic [fgw_pkg::OUT_W-1:0] out_rdata;
  logic resp_en;
  logic [fgw_pkg::PIX_W-1:0] resp_pix;

  fgw_pkg::div_req_t div_req;
  fgw_pkg::div_rsp_t div_rsp;

  logic [fgw_pkg::ADDR_W-1:0] addr_item;
  logic in_fr_item;
  logic kx_pos;
  logic ky_pos;
  logic kx_big;
  logic ky_big;
  logic [DW-1:0] cx;
  logic [DW-1:0] cy;
  logic signed [SX_W-1:0] bsx;
  logic signed [SX_W-1:0] bsy;
  logic bk_in;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MB_W-1:0] dcx;
  logic signed [MB_W-1:0] dcy;
  logic signed [MB_W-1:0] xb;
  logic signed [MB_W-1:0] yb;
  logic signed [ACC_W-1:0] absx;
  logic signed [ACC_W-1:0] absy;
  logic signed [ACC_W-1:0] prod_ext;
  logic [DW-1:0] cxo;
  logic [DW-1:0] cyo;
  logic signed [DX_W-1:0] dx;
  logic signed [DX_W-1:0] dy;
  logic dest_in;
  logic fill_cond;
  logic fsrc_in;

  assign addr_item = {y_q, x_q};
  assign in_fr_item = ({1'b0, x_q} < frame_w) && ({1'b0, y_q} < frame_h);
  assign kx_pos = !coef_x[fgw_pkg::COEF_W-1] && (coef_x != '0);
  assign ky_pos = !coef_y[fgw_pkg::COEF_W-1] && (coef_y != '0);
  assign kx_big = coef_x > COEF_ONE;
  assign ky_big = coef_y > COEF_ONE;
  assign cx = frame_w >> 1;
  assign cy = frame_h >> 1;

  always_comb begin
    bsx = $signed({{(SX_W-CW){1'b0}}, x_q});
    bsy = $signed({{(SX_W-CW){1'b0}}, y_q});
    case (warp_mode)
      fgw_pkg::MODE_TRANSLATE: begin
        bsx = $signed({{(SX_W-CW){1'b0}}, x_q}) - SX_W'(coef_x);
        bsy = $signed({{(SX_W-CW){1'b0}}, y_q}) + SX_W'(coef_y);
      end
      fgw_pkg::MODE_MIRROR_V: begin
        bsy = $signed({{(SX_W-DW){1'b0}}, frame_h}) - SX_W'(1)
            - $signed({{(SX_W-CW){1'b0}}, y_q});
      end
      fgw_pkg::MODE_MIRROR_H: begin
        bsx = $signed({{(SX_W-DW){1'b0}}, frame_w}) - SX_W'(1)
            - $signed({{(SX_W-CW){1'b0}}, x_q});
      end
      default: begin
      end
    endcase
  end

  assign bk_in = in_lim(DX_W'(bsx), frame_w) && in_lim(DX_W'(bsy), frame_h);

  assign dcx = $signed({1'b0, cx}) - $signed({2'b0, x_q});
  assign dcy = $signed({1'b0, cy}) - $signed({2'b0, y_q});
  assign xb = $signed({2'b0, x_q});
  assign yb = $signed({2'b0, y_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (op_q == fgw_pkg::OP_READ) begin
      case (step)
        3'd0: begin
          mul_a = MA_W'(coef_x);
          mul_b = $signed({1'b0, frame_w});
        end
        3'd2: begin
          mul_a = MA_W'(coef_y);
          mul_b = $signed({1'b0, frame_h});
        end
        default: begin
        end
      endcase
    end else begin
      case (warp_mode)
        fgw_pkg::MODE_ROTATE: begin
          case (step)
            3'd0: begin
              mul_a = MA_W'(coef_x);
              mul_b = dcx;
            end
            3'd1: begin
              mul_a = MA_W'(coef_y);
              mul_b = dcy;
            end
            3'd2: begin
              mul_a = MA_W'(coef_x);
              mul_b = dcy;
            end
            3'd3: begin
              mul_a = -MA_W'(coef_y);
              mul_b = dcx;
            end
            default: begin
            end
          endcase
        end
        fgw_pkg::MODE_SCALE: begin
          case (step)
            3'd0: begin
              mul_a = MA_W'(coef_x);
              mul_b = xb;
            end
            3'd2: begin
              mul_a = MA_W'(coef_y);
              mul_b = yb;
            end
            default: begin
            end
          endcase
        end
        fgw_pkg::MODE_SHEAR: begin
          case (step)
            3'd0: begin
              mul_a = MUL_ONE;
              mul_b = xb;
            end
            3'd1: begin
              mul_a = MA_W'(coef_x);
              mul_b = yb;
            end
            3'd2: begin
              mul_a = MUL_ONE;
              mul_b = yb;
            end
            3'd3: begin
              mul_a = MA_W'(coef_y);
              mul_b = xb;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign prod_ext = $signed({prod[PROD_W-1], prod});
  assign absx = accx[ACC_W-1] ? -accx : accx;
  assign absy = accy[ACC_W-1] ? -accy : accy;

  assign cxo = (warp_mode == fgw_pkg::MODE_ROTATE) ? cx : '0;
  assign cyo = (warp_mode == fgw_pkg::MODE_ROTATE) ? cy : '0;
  assign dx = negx ? $signed({{(DX_W-DW){1'b0}}, cxo}) - $signed({2'b0, magx})
                   : $signed({{(DX_W-DW){1'b0}}, cxo}) + $signed({2'b0, magx});
  assign dy = negy ? $signed({{(DX_W-DW){1'b0}}, cyo}) - $signed({2'b0, magy})
                   : $signed({{(DX_W-DW){1'b0}}, cyo}) + $signed({2'b0, magy});
  assign dest_in = in_lim(dx, frame_w) && in_lim(dy, frame_h);

  assign fill_cond = !out_q[fgw_pkg::PIX_W]
      && ($signed({{(ACC_W-fgw_pkg::DVD_W){1'b0}}, x_q, {fgw_pkg::Q_FRAC{1'b0}}}) < accx)
      && ($signed({{(ACC_W-fgw_pkg::DVD_W){1'b0}}, y_q, {fgw_pkg::Q_FRAC{1'b0}}}) < accy);
  assign fsrc_in = ({1'b0, sx} < frame_w) && ({1'b0, sy} < frame_h);

  always_comb begin
    div_req.start = ((state == S_FCHK) && fill_cond) || ((state == S_DIVX) && div_rsp.done);
    if (state == S_FCHK) begin
      div_req.dividend = {x_q, {fgw_pkg::Q_FRAC{1'b0}}};
      div_req.divisor = coef_x[fgw_pkg::DVS_W-1:0];
    end else begin
      div_req.dividend = {y_q, {fgw_pkg::Q_FRAC{1'b0}}};
      div_req.divisor = coef_y[fgw_pkg::DVS_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    src_we = 1'b0;
    src_re = 1'b0;
    src_raddr = addr_item;
    out_we = 1'b0;
    out_re = 1'b0;
    out_waddr = addr_item;
    out_wdata = {1'b0, fgw_pkg::WHITE};
    resp_en = 1'b0;
    resp_pix = fgw_pkg::WHITE;
    unique case (state)
      S_CLEAR: begin
        out_we = 1'b1;
        out_waddr = clr_addr;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (op_q)
          fgw_pkg::OP_LOAD: begin
            src_we = in_fr_item;
            out_we = in_fr_item;
          end
          fgw_pkg::OP_SCATTER: begin
            if (in_fr_item && ((warp_mode == fgw_pkg::MODE_ROTATE)
                || (warp_mode == fgw_pkg::MODE_SHEAR)
                || ((warp_mode == fgw_pkg::MODE_SCALE) && kx_pos && ky_pos))) begin
              src_re = 1'b1;
              state_next = S_MUL;
            end
          end
          fgw_pkg::OP_READ: begin
            if (!in_fr_item) begin
              resp_en = 1'b1;
            end else begin
              case (warp_mode) inside
                fgw_pkg::MODE_TRANSLATE, fgw_pkg::MODE_MIRROR_V,
                fgw_pkg::MODE_MIRROR_H: begin
                  if (bk_in) begin
                    src_re = 1'b1;
                    src_raddr = {bsy[CW-1:0], bsx[CW-1:0]};
                    state_next = S_RSRC;
                  end else begin
                    resp_en = 1'b1;
                  end
                end
                default: begin
                  out_re = 1'b1;
                  if ((warp_mode == fgw_pkg::MODE_SCALE) && kx_pos && ky_pos
                      && (kx_big || ky_big)) begin
                    state_next = S_MUL;
                  end else begin
                    state_next = S_ROUT;
                  end
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end
      S_MUL: begin
        if (step == STEP_LAST) begin
          state_next = (op_q == fgw_pkg::OP_READ) ? S_FCHK : S_TRUNC;
        end
      end
      S_TRUNC: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        out_we = dest_in;
        out_waddr = {dy[CW-1:0], dx[CW-1:0]};
        out_wdata = {1'b1, src_q};
        state_next = S_IDLE;
      end
      S_FCHK: begin
        if (fill_cond) begin
          state_next = S_DIVX;
        end else begin
          resp_en = 1'b1;
          resp_pix = out_q[fgw_pkg::PIX_W-1:0];
          state_next = S_IDLE;
        end
      end
      S_DIVX: begin
        if (div_rsp.done) begin
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_rsp.done) begin
          state_next = S_FSRC;
        end
      end
      S_FSRC: begin
        if (fsrc_in) begin
          src_re = 1'b1;
          src_raddr = {sy, sx};
          state_next = S_RSRC;
        end else begin
          resp_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RSRC: begin
        resp_en = 1'b1;
        resp_pix = src_rdata;
        state_next = S_IDLE;
      end
      S_ROUT: begin
        resp_en = 1'b1;
        resp_pix = out_rdata[fgw_pkg::PIX_W-1:0];
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step <= '0;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= resp_en;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_EXEC) begin
        step <= '0;
      end else if ((state == S_MUL) && (step != STEP_LAST)) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warp_mode <= fgw_pkg::MODE_TRANSLATE;
      frame_w <= DW'(fgw_pkg::MAX_DIM);
      frame_h <= DW'(fgw_pkg::MAX_DIM);
      coef_x <= '0;
      coef_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fgw_pkg::REG_WARP_MODE: warp_mode <= cfg_data[fgw_pkg::MODE_W-1:0];
        fgw_pkg::REG_FRAME_WIDTH: frame_w <= fgw_pkg::eff_dim(cfg_data[DW-1:0]);
        fgw_pkg::REG_FRAME_HEIGHT: frame_h <= fgw_pkg::eff_dim(cfg_data[DW-1:0]);
        fgw_pkg::REG_COEF_X: coef_x <= $signed(cfg_data);
        fgw_pkg::REG_COEF_Y: coef_y <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      op_q <= opcode;
      x_q <= pix_x;
      y_q <= pix_y;
      rgb_q <= {in_red, in_green, in_blue};
    end
    if (state == S_MUL) begin
      prod <= mul_a * mul_b;
      case (step)
        3'd0: begin
          src_q <= src_rdata;
          out_q <= out_rdata;
        end
        3'd1: accx <= prod_ext;
        3'd2: accx <= accx + prod_ext;
        3'd3: accy <= prod_ext;
        default: accy <= accy + prod_ext;
      endcase
    end
    if (state == S_TRUNC) begin
      magx <= absx[ACC_W-1:fgw_pkg::Q_FRAC];
      magy <= absy[ACC_W-1:fgw_pkg::Q_FRAC];
      negx <= accx[ACC_W-1];
      negy <= accy[ACC_W-1];
    end
    if ((state == S_DIVX) && div_rsp.done) begin
      sx <= kx_big ? div_rsp.quotient[CW-1:0] : x_q;
    end
    if ((state == S_DIVY) && div_rsp.done) begin
      sy <= ky_big ? div_rsp.quotient[CW-1:0] : y_q;
    end
    if (resp_en) begin
      res_pix <= resp_pix;
    end
  end

  fgw_ram #(
    .WIDTH(fgw_pkg::PIX_W),
    .DEPTH(fgw_pkg::DEPTH)
  ) u_src_ram (
    .clk  (clk),
    .we   (src_we),
    .waddr(addr_item),
    .wdata(rgb_q),
    .re   (src_re),
    .raddr(src_raddr),
    .rdata(src_rdata)
  );

  fgw_ram #(
    .WIDTH(fgw_pkg::OUT_W),
    .DEPTH(fgw_pkg::DEPTH)
  ) u_out_ram (
    .clk  (clk),
    .we   (out_we),
    .waddr(out_waddr),
    .wdata(out_wdata),
    .re   (out_re),
    .raddr(addr_item),
    .rdata(out_rdata)
  );

  fgw_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign busy = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_red = res_pix[fgw_pkg::PIX_W-1:2*fgw_pkg::CHAN_W];
  assign out_green = res_pix[2*fgw_pkg::CHAN_W-1:fgw_pkg::CHAN_W];
  assign out_blue = res_pix[fgw_pkg::CHAN_W-1:0];

endmodule

/* sv/fgw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for every frame store of the warp unit; no dependencies.
module fgw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/fgw_div.sv */
// Restoring divider producing one quotient bit per cycle for the scale fill.
// Depends on fgw_pkg for widths and the request and response structs.
module fgw_div (
  input  logic              clk,
  input  logic              rst,
  input  fgw_pkg::div_req_t req,
  output fgw_pkg::div_rsp_t rsp
);

  logic [fgw_pkg::DVD_W-1:0]     quo;
  logic [fgw_pkg::DVS_W-1:0]     rem;
  logic [fgw_pkg::DVS_W-1:0]     dvs;
  logic [fgw_pkg::DIV_CNT_W-1:0] cnt;
  logic                          run;
  logic                          done;
  logic [fgw_pkg::DVS_W:0]       trial;
  logic                          ge;

  assign trial = {rem, quo[fgw_pkg::DVD_W-1]};
  assign ge = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == fgw_pkg::DIV_CNT_W'(fgw_pkg::DVD_W - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (run) begin
      rem <= ge ? fgw_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[fgw_pkg::DVS_W-1:0];
      quo <= {quo[fgw_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule

/* sv/fgw_checker.sv */
// Port-level checker for the frame geometric warp unit, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module fgw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `FGW_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  `FGW_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `FGW_ASSERT_NXT(a_request_busy, clk, rst, start && !busy, busy)
  `FGW_ASSERT_NXT_ALL(a_reset_clears, clk, rst, busy)

endmodule

bind frame_geometric_warp_unit fgw_checker u_fgw_checker (.*);

/* tb/sv/frame_warp_checker.sv */
`timescale 1ns / 100ps
// Checker of the frame geometric warp unit: follows register writes and requests,
// keeps its own copy of the source, output and mark stores, and compares every read.
// Depends on fgw_pkg for widths and codes; reports a failure count and open reads.
module frame_warp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [fgw_pkg::OP_W-1:0]       opcode,
  input  logic [fgw_pkg::COORD_W-1:0]    pix_x,
  input  logic [fgw_pkg::COORD_W-1:0]    pix_y,
  input  logic [fgw_pkg::CHAN_W-1:0]     in_red,
  input  logic [fgw_pkg::CHAN_W-1:0]     in_green,
  input  logic [fgw_pkg::CHAN_W-1:0]     in_blue,
  input  logic                           done,
  input  logic [fgw_pkg::CHAN_W-1:0]     out_red,
  input  logic [fgw_pkg::CHAN_W-1:0]     out_green,
  input  logic [fgw_pkg::CHAN_W-1:0]     out_blue,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fgw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import fgw_pkg::*;

  localparam longint Q_ONE = longint'(1) << Q_FRAC;

  typedef struct {
    int               x;
    int               y;
    logic [PIX_W-1:0] pixel;
  } read_expect_t;

  logic [PIX_W-1:0]         source_pix [DEPTH];
  logic [PIX_W-1:0]         output_pix [DEPTH];
  bit                       written    [DEPTH];
  logic [MODE_W-1:0]        mode_q;
  logic [DIM_W-1:0]         width_q;
  logic [DIM_W-1:0]         height_q;
  logic signed [COEF_W-1:0] coef_x_q;
  logic signed [COEF_W-1:0] coef_y_q;
  read_expect_t             expected_reads [$];
  int                       errors = 0;

  initial begin
    foreach (output_pix[i]) begin
      source_pix[i] = '0;
      output_pix[i] = WHITE;
      written[i] = 1'b0;
    end
  end

  function automatic longint size_in_use(logic [DIM_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > MAX_DIM) begin
      return MAX_DIM;
    end
    return longint'(v);
  endfunction

  function automatic bit in_frame(longint x, longint y);
    return x >= 0 && y >= 0 && x < size_in_use(width_q) && y < size_in_use(height_q);
  endfunction

  function automatic longint q8_trunc(longint v);
    if (v >= 0) begin
      return v >>> Q_FRAC;
    end
    return -((-v) >>> Q_FRAC);
  endfunction

  function automatic int pixel_addr(longint x, longint y);
    return int'(y * MAX_DIM + x);
  endfunction

  function automatic logic [PIX_W-1:0] source_or_white(longint x, longint y);
    if (!in_frame(x, y)) begin
      return WHITE;
    end
    return source_pix[pixel_addr(x, y)];
  endfunction

  function automatic void apply_load(longint x, longint y, logic [PIX_W-1:0] rgb);
    int a;
    if (in_frame(x, y)) begin
      a = pixel_addr(x, y);
      source_pix[a] = rgb;
      output_pix[a] = WHITE;
      written[a] = 1'b0;
    end
  endfunction

  function automatic void apply_scatter(longint x, longint y);
    longint w, h, kx, ky, cx, cy, dx, dy;
    int a;
    w = size_in_use(width_q);
    h = size_in_use(height_q);
    kx = longint'(coef_x_q);
    ky = longint'(coef_y_q);
    if (!in_frame(x, y)) begin
      return;
    end
    case (mode_q)
      MODE_ROTATE: begin
        cx = w / 2;
        cy = h / 2;
        dx = q8_trunc(kx * (cx - x) + ky * (cy - y)) + cx;
        dy = q8_trunc(kx * (cy - y) - ky * (cx - x)) + cy;
      end
      MODE_SCALE: begin
        if (kx <= 0 || ky <= 0) begin
          return;
        end
        dx = (kx * x) >>> Q_FRAC;
        dy = (ky * y) >>> Q_FRAC;
      end
      MODE_SHEAR: begin
        dx = q8_trunc(Q_ONE * x + kx * y);
        dy = q8_trunc(Q_ONE * y + ky * x);
      end
      default: begin
        return;
      end
    endcase
    if (!in_frame(dx, dy)) begin
      return;
    end
    a = pixel_addr(dx, dy);
    output_pix[a] = source_pix[pixel_addr(x, y)];
    written[a] = 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] predict_read(longint x, longint y);
    longint w, h, kx, ky, sx, sy;
    int a;
    w = size_in_use(width_q);
    h = size_in_use(height_q);
    kx = longint'(coef_x_q);
    ky = longint'(coef_y_q);
    if (!in_frame(x, y)) begin
      return WHITE;
    end
    case (mode_q)
      MODE_TRANSLATE: return source_or_white(x - kx, y + ky);
      MODE_MIRROR_V:  return source_or_white(x, h - 1 - y);
      MODE_MIRROR_H:  return source_or_white(w - 1 - x, y);
      default: ;
    endcase
    a = pixel_addr(x, y);
    if (mode_q == MODE_SCALE && kx > 0 && ky > 0 && !written[a] &&
        Q_ONE * x < w * kx && Q_ONE * y < h * ky && (kx > Q_ONE || ky > Q_ONE)) begin
      sx = (kx > Q_ONE) ? (Q_ONE * x) / kx : x;
      sy = (ky > Q_ONE) ? (Q_ONE * y) / ky : y;
      return source_or_white(sx, sy);
    end
    return output_pix[a];
  endfunction

  task automatic compare_channel(string name, read_expect_t e, int lsb,
                                 logic [CHAN_W-1:0] got);
    if (got !== e.pixel[lsb +: CHAN_W]) begin
      $display("%0t: read (%0d,%0d) %s expected %02h, got %02h", $time, e.x, e.y, name,
               e.pixel[lsb +: CHAN_W], got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    read_expect_t e;
    if (rst) begin
      mode_q = MODE_TRANSLATE;
      width_q = DIM_W'(MAX_DIM);
      height_q = DIM_W'(MAX_DIM);
      coef_x_q = '0;
      coef_y_q = '0;
      expected_reads.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WARP_MODE:    mode_q = cfg_data[MODE_W-1:0];
          REG_FRAME_WIDTH:  width_q = cfg_data[DIM_W-1:0];
          REG_FRAME_HEIGHT: height_q = cfg_data[DIM_W-1:0];
          REG_COEF_X:       coef_x_q = cfg_data;
          REG_COEF_Y:       coef_y_q = cfg_data;
          default: ;
        endcase
      end
      if (done === 1'b1) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: result %02h%02h%02h arrived with no read outstanding", $time,
                   out_red, out_green, out_blue);
          errors++;
        end else begin
          e = expected_reads.pop_front();
          compare_channel("red", e, 2 * CHAN_W, out_red);
          compare_channel("green", e, CHAN_W, out_green);
          compare_channel("blue", e, 0, out_blue);
        end
      end
      if (start && busy === 1'b0) begin
        case (opcode)
          OP_LOAD:    apply_load(pix_x, pix_y, {in_red, in_green, in_blue});
          OP_SCATTER: apply_scatter(pix_x, pix_y);
          OP_READ: begin
            e.x = pix_x;
            e.y = pix_y;
            e.pixel = predict_read(pix_x, pix_y);
            expected_reads.push_back(e);
          end
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending <= expected_reads.size();
  end

endmodule

/* tb/sv/frame_geometric_warp_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench top of the frame geometric warp unit: clock, reset, request and
// register-write stimulus, a stall watchdog and the verdict.
// Depends on fgw_pkg, frame_geometric_warp_unit and frame_warp_checker.
module frame_geometric_warp_unit_tb;
  import fgw_pkg::*;

  localparam int STALL_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 50;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 136;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [OP_W-1:0]       opcode = '0;
  logic [COORD_W-1:0]    pix_x = '0;
  logic [COORD_W-1:0]    pix_y = '0;
  logic [CHAN_W-1:0]     in_red = '0;
  logic [CHAN_W-1:0]     in_green = '0;
  logic [CHAN_W-1:0]     in_blue = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  done;
  logic                  cfg_ready;
  logic [CHAN_W-1:0]     out_red;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_blue;
  int                    fail_count;
  int                    pending;

  int                    idle_pct = 0;
  int                    requests_sent = 0;
  int                    reads_sent = 0;
  int                    settings_used = 0;
  bit                    loaded [DEPTH];
  logic [MODE_W-1:0]     mode_now = MODE_TRANSLATE;
  int                    w_now = MAX_DIM;
  int                    h_now = MAX_DIM;
  int                    kx_now = 0;
  int                    ky_now = 0;

  always #4 clk = ~clk;

  frame_geometric_warp_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .pix_x(pix_x), .pix_y(pix_y), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .done(done), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frame_warp_checker CHECK (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .pix_x(pix_x), .pix_y(pix_y), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .done(done), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending(pending)
  );

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int size_in_use(int v);
    int m;
    m = v & 511;
    if (m == 0) begin
      return 1;
    end
    return (m > MAX_DIM) ? MAX_DIM : m;
  endfunction

  // True when the request may fetch a source pixel inside the frame; sx, sy give it.
  function automatic bit reads_source(logic [OP_W-1:0] op, int x, int y,
                                      output int sx, output int sy);
    bit need;
    need = 1'b0;
    sx = x;
    sy = y;
    if (x >= w_now || y >= h_now) begin
      return 1'b0;
    end
    if (op == OP_SCATTER) begin
      need = (mode_now == MODE_ROTATE) || (mode_now == MODE_SHEAR) ||
             (mode_now == MODE_SCALE && kx_now > 0 && ky_now > 0);
    end else if (op == OP_READ) begin
      case (mode_now)
        MODE_TRANSLATE: begin
          sx = x - kx_now;
          sy = y + ky_now;
          need = 1'b1;
        end
        MODE_MIRROR_V: begin
          sy = h_now - 1 - y;
          need = 1'b1;
        end
        MODE_MIRROR_H: begin
          sx = w_now - 1 - x;
          need = 1'b1;
        end
        MODE_SCALE: begin
          if (kx_now > 0 && ky_now > 0 && (kx_now > 256 || ky_now > 256) &&
              256 * x < w_now * kx_now && 256 * y < h_now * ky_now) begin
            if (kx_now > 256) sx = 256 * x / kx_now;
            if (ky_now > 256) sy = 256 * y / ky_now;
            need = 1'b1;
          end
        end
        default: ;
      endcase
    end
    return need && sx >= 0 && sy >= 0 && sx < w_now && sy < h_now;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, int x, int y, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    pix_x <= COORD_W'(x);
    pix_y <= COORD_W'(y);
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (op == OP_LOAD && x < w_now && y < h_now) begin
      loaded[y * MAX_DIM + x] = 1'b1;
    end
    if (op == OP_READ) begin
      reads_sent++;
    end
    requests_sent++;
  endtask

  task automatic issue(logic [OP_W-1:0] op, int x, int y, logic [7:0] r,
                       logic [7:0] g, logic [7:0] b);
    int sx, sy;
    if (reads_source(op, x, y, sx, sy) && !loaded[sy * MAX_DIM + sx]) begin
      send_item(OP_LOAD, sx, sy, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    send_item(op, x, y, r, g, b);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, int w, int h, int kx, int ky);
    logic signed [COEF_W-1:0] cx, cy;
    settle();
    write_reg(REG_WARP_MODE, mode);
    write_reg(REG_FRAME_WIDTH, w & 511);
    write_reg(REG_FRAME_HEIGHT, h & 511);
    write_reg(REG_COEF_X, kx);
    write_reg(REG_COEF_Y, ky);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cx = COEF_W'(kx);
    cy = COEF_W'(ky);
    mode_now = mode;
    w_now = size_in_use(w);
    h_now = size_in_use(h);
    kx_now = cx;
    ky_now = cy;
    settings_used++;
  endtask

  task automatic directed_checks();
    issue(OP_LOAD, 0, 0, 8'h00, 8'h00, 8'h00);
    issue(OP_LOAD, 255, 255, 8'hFF, 8'h00, 8'hFF);
    issue(OP_LOAD, 128, 1, 8'h5A, 8'hA5, 8'h3C);
    issue(OP_READ, 0, 0, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 255, 255, 8'h00, 8'h00, 8'h00);
    issue(OP_SCATTER, 128, 1, 8'h00, 8'h00, 8'h00);
    issue(OP_SPARE, 255, 255, 8'hFF, 8'hFF, 8'hFF);
    issue(OP_READ, 128, 1, 8'h00, 8'h00, 8'h00);
    configure(MODE_MIRROR_V, 0, 511, 0, 0);
    issue(OP_LOAD, 200, 3, 8'h11, 8'h22, 8'h33);
    issue(OP_READ, 200, 3, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 0, 0, 8'h00, 8'h00, 8'h00);
    configure(MODE_MIRROR_H, 256, 2, 0, 0);
    issue(OP_READ, 255, 1, 8'h00, 8'h00, 8'h00);
    configure(MODE_TRANSLATE, 256, 256, -32768, 32767);
    issue(OP_READ, 0, 0, 8'h00, 8'h00, 8'h00);
    configure(MODE_ROTATE, 256, 256, 0, 256);
    issue(OP_SCATTER, 10, 20, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 236, 10, 8'h00, 8'h00, 8'h00);
    configure(MODE_SHEAR, 256, 256, 256, 0);
    issue(OP_SCATTER, 200, 200, 8'h00, 8'h00, 8'h00);
    issue(OP_SCATTER, 10, 20, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 30, 20, 8'h00, 8'h00, 8'h00);
    configure(MODE_SCALE, 16, 16, 512, 384);
    issue(OP_SCATTER, 3, 3, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 6, 4, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 7, 5, 8'h00, 8'h00, 8'h00);
    configure(MODE_SCALE, 16, 16, 0, 512);
    issue(OP_SCATTER, 4, 4, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 8, 8, 8'h00, 8'h00, 8'h00);
    configure(MODE_SPARE_6, 16, 16, 256, 256);
    issue(OP_SCATTER, 1, 1, 8'h00, 8'h00, 8'h00);
    issue(OP_READ, 1, 1, 8'h00, 8'h00, 8'h00);
    configure(MODE_SPARE_7, 16, 16, 256, 256);
    issue(OP_READ, 2, 2, 8'h00, 8'h00, 8'h00);
    settle();
    write_reg(REG_SPARE_5, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h0000);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MODE_W-1:0] mode_for_phase(int p);
    case (p)
      0, 11:    return MODE_TRANSLATE;
      1, 7, 13: return MODE_ROTATE;
      2, 6, 12: return MODE_SCALE;
      3, 9:     return MODE_SHEAR;
      4:        return MODE_MIRROR_V;
      5:        return MODE_MIRROR_H;
      8:        return MODE_SPARE_6;
      default:  return MODE_SPARE_7;
    endcase
  endfunction

  task automatic random_config(logic [MODE_W-1:0] mode, bit wide);
    int w, h, kx, ky, roll;
    int sines [5];
    int cosines [5];
    sines = '{256, 0, -256, 181, 0};
    cosines = '{0, -256, 0, 181, 256};
    roll = $urandom_range(0, 3);
    if (wide) begin
      w = (roll == 0) ? 511 : (roll == 1) ? rand_between(129, 255) : 256;
      h = (roll == 0) ? 300 : (roll == 1) ? 0 : (roll == 2) ? 256 : rand_between(1, 40);
    end else begin
      w = (roll == 0) ? 0 : rand_between(1, 24);
      h = rand_between(1, 24);
    end
    roll = $urandom_range(0, 5);
    case (mode)
      MODE_TRANSLATE: begin
        if (roll == 0) begin
          kx = -32768;
          ky = 32767;
        end else begin
          kx = rand_between(-size_in_use(w), size_in_use(w));
          ky = rand_between(-size_in_use(h), size_in_use(h));
        end
      end
      MODE_ROTATE: begin
        if (roll == 5) begin
          kx = rand_between(-256, 256);
          ky = rand_between(-256, 256);
        end else begin
          kx = sines[roll];
          ky = cosines[roll];
        end
      end
      MODE_SCALE: begin
        if (roll == 0) begin
          kx = 0;
          ky = -256;
        end else begin
          kx = (roll == 1) ? rand_between(1, 1024) : 128 * rand_between(1, 6);
          ky = (roll == 2) ? rand_between(1, 1024) : 128 * rand_between(1, 6);
        end
      end
      MODE_SHEAR: begin
        kx = (roll == 0) ? 32767 : rand_between(-256, 256);
        ky = (roll == 0) ? -32768 : rand_between(-256, 256);
      end
      default: begin
        kx = int'($urandom_range(0, 65535));
        ky = int'($urandom_range(0, 65535));
      end
    endcase
    configure(mode, w, h, kx, ky);
  endtask

  task automatic random_phase(int n);
    int first, x, y, roll;
    logic [OP_W-1:0] op;
    first = requests_sent;
    while (requests_sent - first < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        op = OP_SPARE;
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end else if (roll < 10) begin
        op = OP_W'($urandom_range(0, 2));
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end else begin
        op = (roll < 25) ? OP_LOAD : (roll < 60) ? OP_SCATTER : OP_READ;
        x = $urandom_range(0, w_now - 1);
        y = $urandom_range(0, h_now - 1);
      end
      issue(op, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[frame_geometric_warp_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    int p;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_checks();
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        1:       idle_pct = 77;
        3:       idle_pct = 21;
        default: idle_pct = 0;
      endcase
      random_config(mode_for_phase(p), (p % 5 == 3) || (p == 4));
      random_phase(PHASE_ITEMS);
    end
    settle();
    $display("Covered %0d requests, %0d of them pixel reads, under %0d register settings",
             requests_sent, reads_sent, settings_used);
    $display("spanning all warp modes, the spare codes, frame size extremes and idle gaps.");
    if (fail_count == 0 && pending == 0) begin
      $display("[frame_geometric_warp_unit] OK");
    end else begin
      $display("[frame_geometric_warp_unit] ERROR");
    end
    $finish;
  end

endmodule
